// ----- rtl/sphere_mesh_triangle_generator_top_assert.svh -----
// Assertion macros for the sphere mesh RTL
`ifndef SPHERE_MESH_TRIANGLE_GENERATOR_TOP_ASSERT_SVH
`define SPHERE_MESH_TRIANGLE_GENERATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define SMTG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("smtg check failed");
`define SMTG_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error("smtg bad state");
`else
`define SMTG_ASSERT(lbl, prop)
`define SMTG_NEVER(lbl, expr)
`endif
`endif

// ----- rtl/smtg_pkg.sv -----
// Types, constants and fixed-point helpers for the sphere mesh generator
package smtg_pkg;

  localparam int TRIG_W    = 18;
  localparam int COORD_W   = 32;
  localparam int RAD_W     = 31;
  localparam int TRIG_FRAC = 16;
  localparam int TRIG_ONE  = 65536;
  localparam int PROD_W    = COORD_W + TRIG_W;
  localparam int ACC_W     = PROD_W + 1;
  localparam int RND_W     = ACC_W - TRIG_FRAC;
  localparam int FL_W      = 7;
  localparam int ADDR_W    = 5;

  // register indexes
  localparam logic [2:0] REG_FACE_LEVEL = 3'd0;
  localparam logic [2:0] REG_COS_POLAR  = 3'd1;
  localparam logic [2:0] REG_SIN_POLAR  = 3'd2;
  localparam logic [2:0] REG_COS_AZ     = 3'd3;
  localparam logic [2:0] REG_SIN_AZ     = 3'd4;
  localparam logic [2:0] REG_SUBDIV     = 3'd5;
  localparam logic [2:0] REG_FILL       = 3'd6;

  typedef enum logic {ITEM_START = 1'b0, ITEM_ADVANCE = 1'b1} item_kind_t;

  typedef struct packed {
    item_kind_t                  kind;
    logic signed [COORD_W-1:0]   cx;
    logic signed [COORD_W-1:0]   cy;
    logic signed [COORD_W-1:0]   cz;
    logic        [RAD_W-1:0]     rad;
  } item_t;

  typedef struct packed {
    logic        [FL_W-1:0]    face_level;
    logic signed [TRIG_W-1:0]  cos_polar;
    logic signed [TRIG_W-1:0]  sin_polar;
    logic signed [TRIG_W-1:0]  cos_az;
    logic signed [TRIG_W-1:0]  sin_az;
  } cfg_t;

  // front to back hand-off
  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

  // round half up, drop TRIG_FRAC fraction bits
  function automatic logic signed [RND_W-1:0] rnd(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] x;
    x = v + ACC_W'(1 << (TRIG_FRAC - 1));
    return $signed(x[ACC_W-1:TRIG_FRAC]);
  endfunction

  function automatic logic signed [TRIG_W-1:0] sat_trig(input logic signed [RND_W-1:0] v);
    if (v > RND_W'(TRIG_ONE)) return TRIG_W'(TRIG_ONE);
    if (v < -RND_W'(TRIG_ONE)) return -TRIG_W'(TRIG_ONE);
    return v[TRIG_W-1:0];
  endfunction

  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [RND_W:0] v);
    logic signed [RND_W:0] hi;
    logic signed [RND_W:0] lo;
    hi = (RND_W+1)'(2147483647);
    lo = -hi - (RND_W+1)'(1);
    if (v > hi) return hi[COORD_W-1:0];
    if (v < lo) return lo[COORD_W-1:0];
    return v[COORD_W-1:0];
  endfunction

endpackage

// ----- rtl/sphere_mesh_triangle_generator_top.sv -----
// Sphere mesh triangle generator: top level
// A start request loads center and radius. An advance request is dispatched
// from IDLE, runs 27 sequence steps around a single shared 32x18 multiplier
// (trig rotations, corner factors, radius scaling), then emits up to two
// triangles from an output register, one per cycle while the output is not
// stalled. A two-entry request queue lets new requests arrive while a cell
// is computed or a triangle waits downstream.
module sphere_mesh_triangle_generator_top #(
  parameter int MAX_FACE_LEVEL = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [smtg_pkg::ADDR_W-1:0]         paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  logic                                func,
  input  logic signed [smtg_pkg::COORD_W-1:0] center_x,
  input  logic signed [smtg_pkg::COORD_W-1:0] center_y,
  input  logic signed [smtg_pkg::COORD_W-1:0] center_z,
  input  logic        [smtg_pkg::RAD_W-1:0]   sphere_radius,
  output logic                                tri_valid,
  input  logic                                tri_stall,
  output logic signed [smtg_pkg::COORD_W-1:0] vertex_a_x,
  output logic signed [smtg_pkg::COORD_W-1:0] vertex_a_y,
  output logic signed [smtg_pkg::COORD_W-1:0] vertex_a_z,
  output logic signed [smtg_pkg::COORD_W-1:0] vertex_b_x,
  output logic signed [smtg_pkg::COORD_W-1:0] vertex_b_y,
  output logic signed [smtg_pkg::COORD_W-1:0] vertex_b_z,
  output logic signed [smtg_pkg::COORD_W-1:0] vertex_c_x,
  output logic signed [smtg_pkg::COORD_W-1:0] vertex_c_y,
  output logic signed [smtg_pkg::COORD_W-1:0] vertex_c_z,
  output logic                                triangle_kind,
  output logic                                run_last,
  output logic                                sphere_done
);

  smtg_pkg::cfg_t        cfg;
  smtg_pkg::queue_head_t head;
  logic                  pop;

  smtg_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  smtg_front u_front (
    .clk, .rst, .req_valid, .req_stall, .func, .center_x, .center_y, .center_z,
    .sphere_radius, .head, .pop
  );

  smtg_back #(.MAX_FACE_LEVEL(MAX_FACE_LEVEL)) u_back (
    .clk, .rst, .cfg, .head, .pop, .tri_valid, .tri_stall,
    .vertex_a_x, .vertex_a_y, .vertex_a_z,
    .vertex_b_x, .vertex_b_y, .vertex_b_z,
    .vertex_c_x, .vertex_c_y, .vertex_c_z,
    .triangle_kind, .run_last, .sphere_done
  );

endmodule

// ----- rtl/smtg_regs.sv -----
// APB configuration registers
module smtg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [smtg_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output smtg_pkg::cfg_t                cfg
);

  logic [3:0] subdiv;
  logic [1:0] fill;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[4:2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.face_level <= smtg_pkg::FL_W'(12);
      cfg.cos_polar  <= smtg_pkg::TRIG_W'(65272);
      cfg.sin_polar  <= smtg_pkg::TRIG_W'(5875);
      cfg.cos_az     <= smtg_pkg::TRIG_W'(65280);
      cfg.sin_az     <= smtg_pkg::TRIG_W'(5792);
      subdiv         <= 4'd0;
      fill           <= 2'd1;
    end else if (wr_en) begin
      unique case (idx)
        smtg_pkg::REG_FACE_LEVEL: cfg.face_level <= pwdata[smtg_pkg::FL_W-1:0];
        smtg_pkg::REG_COS_POLAR:  cfg.cos_polar  <= pwdata[smtg_pkg::TRIG_W-1:0];
        smtg_pkg::REG_SIN_POLAR:  cfg.sin_polar  <= pwdata[smtg_pkg::TRIG_W-1:0];
        smtg_pkg::REG_COS_AZ:     cfg.cos_az     <= pwdata[smtg_pkg::TRIG_W-1:0];
        smtg_pkg::REG_SIN_AZ:     cfg.sin_az     <= pwdata[smtg_pkg::TRIG_W-1:0];
        smtg_pkg::REG_SUBDIV:     subdiv         <= pwdata[3:0];
        smtg_pkg::REG_FILL:       fill           <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      smtg_pkg::REG_FACE_LEVEL: prdata = 32'(cfg.face_level);
      smtg_pkg::REG_COS_POLAR:  prdata = 32'(unsigned'(cfg.cos_polar));
      smtg_pkg::REG_SIN_POLAR:  prdata = 32'(unsigned'(cfg.sin_polar));
      smtg_pkg::REG_COS_AZ:     prdata = 32'(unsigned'(cfg.cos_az));
      smtg_pkg::REG_SIN_AZ:     prdata = 32'(unsigned'(cfg.sin_az));
      smtg_pkg::REG_SUBDIV:     prdata = 32'(subdiv);
      smtg_pkg::REG_FILL:       prdata = 32'(fill);
      default:                  prdata = 32'd0;
    endcase
  end

endmodule

// ----- rtl/smtg_front.sv -----
// Request intake: classifies requests and queues them for the back end
module smtg_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  logic                              func,
  input  logic signed [smtg_pkg::COORD_W-1:0] center_x,
  input  logic signed [smtg_pkg::COORD_W-1:0] center_y,
  input  logic signed [smtg_pkg::COORD_W-1:0] center_z,
  input  logic        [smtg_pkg::RAD_W-1:0]   sphere_radius,
  output smtg_pkg::queue_head_t             head,
  input  logic                              pop
);

  smtg_pkg::item_t slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  smtg_pkg::item_t incoming;

  assign req_stall = (count == 2'd2);
  assign push      = req_valid && !req_stall;

  // classify the request
  always_comb begin
    incoming.kind = func ? smtg_pkg::ITEM_ADVANCE : smtg_pkg::ITEM_START;
    incoming.cx   = center_x;
    incoming.cy   = center_y;
    incoming.cz   = center_z;
    incoming.rad  = sphere_radius;
  end

  // two-entry queue
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        slot[wr_ptr] <= incoming;
        wr_ptr       <= !wr_ptr;
      end
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  assign head.valid = (count != 2'd0);
  assign head.item  = slot[rd_ptr];

endmodule

// ----- rtl/smtg_back.sv -----
// Cell engine: shared multiplier sequence, state update and triangle output
`include "sphere_mesh_triangle_generator_top_assert.svh"
module smtg_back #(
  parameter int MAX_FACE_LEVEL = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  smtg_pkg::cfg_t                      cfg,
  input  smtg_pkg::queue_head_t               head,
  output logic                                pop,
  output logic                                tri_valid,
  input  logic                                tri_stall,
  output logic signed [smtg_pkg::COORD_W-1:0] vertex_a_x,
  output logic signed [smtg_pkg::COORD_W-1:0] vertex_a_y,
  output logic signed [smtg_pkg::COORD_W-1:0] vertex_a_z,
  output logic signed [smtg_pkg::COORD_W-1:0] vertex_b_x,
  output logic signed [smtg_pkg::COORD_W-1:0] vertex_b_y,
  output logic signed [smtg_pkg::COORD_W-1:0] vertex_b_z,
  output logic signed [smtg_pkg::COORD_W-1:0] vertex_c_x,
  output logic signed [smtg_pkg::COORD_W-1:0] vertex_c_y,
  output logic signed [smtg_pkg::COORD_W-1:0] vertex_c_z,
  output logic                                triangle_kind,
  output logic                                run_last,
  output logic                                sphere_done
);

  localparam int TW = smtg_pkg::TRIG_W;
  localparam int CW = smtg_pkg::COORD_W;
  localparam int AW = smtg_pkg::ACC_W;
  localparam int RW = smtg_pkg::RND_W;
  localparam int W_R = $clog2(3 * MAX_FACE_LEVEL + 1);
  localparam int W_S = $clog2(6 * MAX_FACE_LEVEL);
  localparam int W_N = $clog2(6 * MAX_FACE_LEVEL + 4);
  localparam int W_FL = smtg_pkg::FL_W + 1;
  localparam logic [4:0] LAST_STEP = 5'd26;

  typedef enum logic [1:0] {IDLE, CALC, EMIT_UP, EMIT_LO} state_t;

  state_t state;
  logic [4:0] seq;
  logic [4:0] k;

  // sphere state
  logic signed [TW-1:0] pc, ps, ac, as_;
  logic signed [CW-1:0] hcx, hcy, hcz;
  logic [smtg_pkg::RAD_W-1:0] hrad;
  logic [W_R-1:0] ring;
  logic [W_S-1:0] step;
  logic active;

  // cell temporaries
  logic signed [TW-1:0] p_r, q_r, r_r, s_r;
  logic signed [TW-1:0] fac [8];
  logic signed [CW-1:0] xy [8];
  logic signed [CW-1:0] z0, z1;
  logic signed [AW-1:0] acc;
  logic lo_pend, done_f;

  // shared multiplier
  logic signed [CW-1:0] ma;
  logic signed [TW-1:0] mb;
  logic signed [smtg_pkg::PROD_W-1:0] prod;
  logic signed [AW-1:0] prod_x;
  logic signed [RW-1:0] prod_r;
  logic signed [RW:0] ctr_sum;
  logic signed [CW-1:0] ctr_sel;

  // clamped mesh size
  logic [W_FL-1:0] fl;
  logic [W_N-1:0] nt, np;
  logic [W_N-1:0] step_inc;
  logic row_end;
  logic out_free;
  logic emit_fire;

  always_comb begin
    if (cfg.face_level == '0) fl = W_FL'(1);
    else if (W_FL'(cfg.face_level) > W_FL'(MAX_FACE_LEVEL)) fl = W_FL'(MAX_FACE_LEVEL);
    else fl = W_FL'(cfg.face_level);
    nt = W_N'(fl) * W_N'(3);
    np = W_N'(fl) * W_N'(6);
  end

  assign step_inc  = W_N'(step) + W_N'(1);
  assign row_end   = (step_inc + W_N'(1)) >= np;
  assign out_free  = !tri_valid || !tri_stall;
  assign emit_fire = (state == EMIT_UP || state == EMIT_LO) && out_free;
  assign pop       = (state == IDLE) && head.valid;
  assign k         = seq - 5'd1;

  // operand select per sequence step
  always_comb begin
    ma = '0;
    mb = '0;
    case (seq)
      5'd0:  begin ma = CW'(ps);  mb = cfg.cos_polar; end
      5'd1:  begin ma = CW'(pc);  mb = cfg.sin_polar; end
      5'd2:  begin ma = CW'(pc);  mb = cfg.cos_polar; end
      5'd3:  begin ma = CW'(ps);  mb = cfg.sin_polar; end
      5'd4:  begin ma = CW'(ac);  mb = cfg.cos_az;    end
      5'd5:  begin ma = CW'(as_); mb = cfg.sin_az;    end
      5'd6:  begin ma = CW'(as_); mb = cfg.cos_az;    end
      5'd7:  begin ma = CW'(ac);  mb = cfg.sin_az;    end
      5'd8:  begin ma = CW'(ps);  mb = ac;            end
      5'd9:  begin ma = CW'(ps);  mb = as_;           end
      5'd10: begin ma = CW'(p_r); mb = ac;            end
      5'd11: begin ma = CW'(p_r); mb = as_;           end
      5'd12: begin ma = CW'(ps);  mb = r_r;           end
      5'd13: begin ma = CW'(ps);  mb = s_r;           end
      5'd14: begin ma = CW'(p_r); mb = r_r;           end
      5'd15: begin ma = CW'(p_r); mb = s_r;           end
      5'd24: begin ma = {1'b0, hrad}; mb = pc;        end
      5'd25: begin ma = {1'b0, hrad}; mb = q_r;       end
      default: begin
        if (seq >= 5'd16 && seq <= 5'd23) begin
          ma = {1'b0, hrad};
          mb = fac[seq[2:0]];
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
  end

  assign prod_x  = AW'(prod);
  assign prod_r  = smtg_pkg::rnd(prod_x);
  assign ctr_sel = k[0] ? hcy : hcx;

  // consume the product of the previous step
  always_ff @(posedge clk) begin
    if (state == CALC && seq != 5'd0) begin
      case (k) inside
        5'd0, 5'd2, 5'd4, 5'd6: acc <= prod_x;
        5'd1: p_r <= smtg_pkg::sat_trig(smtg_pkg::rnd(acc + prod_x));
        5'd3: q_r <= smtg_pkg::sat_trig(smtg_pkg::rnd(acc - prod_x));
        5'd5: r_r <= smtg_pkg::sat_trig(smtg_pkg::rnd(acc - prod_x));
        5'd7: s_r <= smtg_pkg::sat_trig(smtg_pkg::rnd(acc + prod_x));
        5'd24: z0 <= smtg_pkg::sat32((RW+1)'(prod_r) + (RW+1)'(hcz));
        5'd25: z1 <= smtg_pkg::sat32((RW+1)'(prod_r) + (RW+1)'(hcz));
        default: begin
          if (k >= 5'd8 && k <= 5'd15) fac[k[2:0]] <= prod_r[TW-1:0];
          else if (k >= 5'd16 && k <= 5'd23)
            xy[k[2:0]] <= smtg_pkg::sat32((RW+1)'(prod_r) + (RW+1)'(ctr_sel));
        end
      endcase
    end
  end

  // output valid: set on emit, cleared once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      tri_valid <= 1'b0;
    end else begin
      tri_valid <= emit_fire || (tri_valid && tri_stall);
    end
  end

  // sequencer, sphere state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      seq       <= '0;
      pc        <= TW'(smtg_pkg::TRIG_ONE);
      ps        <= '0;
      ac        <= TW'(smtg_pkg::TRIG_ONE);
      as_       <= '0;
      hcx       <= '0;
      hcy       <= '0;
      hcz       <= '0;
      hrad      <= '0;
      ring      <= '0;
      step      <= '0;
      active    <= 1'b0;
      lo_pend   <= 1'b0;
      done_f    <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          if (head.valid) begin
            if (head.item.kind == smtg_pkg::ITEM_START) begin
              hcx    <= head.item.cx;
              hcy    <= head.item.cy;
              hcz    <= head.item.cz;
              hrad   <= head.item.rad;
              pc     <= TW'(smtg_pkg::TRIG_ONE);
              ps     <= '0;
              ac     <= TW'(smtg_pkg::TRIG_ONE);
              as_    <= '0;
              ring   <= '0;
              step   <= '0;
              active <= 1'b1;
            end else if (active) begin
              seq   <= '0;
              state <= CALC;
            end
          end
        end
        CALC: begin
          seq <= seq + 5'd1;
          if (seq == LAST_STEP) begin
            lo_pend <= (ring != '0);
            ac      <= r_r;
            as_     <= s_r;
            done_f  <= row_end && ((W_N'(ring) + W_N'(2)) >= nt);
            if (row_end) begin
              step <= '0;
              pc   <= q_r;
              ps   <= p_r;
              ring <= ring + W_R'(1);
              if ((W_N'(ring) + W_N'(2)) >= nt) active <= 1'b0;
            end else begin
              step <= step_inc[W_S-1:0];
            end
            if ((W_N'(ring) + W_N'(2)) < nt) state <= EMIT_UP;
            else if (ring != '0) state <= EMIT_LO;
            else state <= IDLE;
          end
        end
        EMIT_UP: begin
          if (out_free) begin
            vertex_a_x    <= xy[0];
            vertex_a_y    <= xy[1];
            vertex_a_z    <= z0;
            vertex_b_x    <= xy[2];
            vertex_b_y    <= xy[3];
            vertex_b_z    <= z1;
            vertex_c_x    <= xy[6];
            vertex_c_y    <= xy[7];
            vertex_c_z    <= z1;
            triangle_kind <= 1'b0;
            run_last      <= !lo_pend;
            sphere_done   <= done_f && !lo_pend;
            state         <= lo_pend ? EMIT_LO : IDLE;
          end
        end
        EMIT_LO: begin
          if (out_free) begin
            vertex_a_x    <= xy[0];
            vertex_a_y    <= xy[1];
            vertex_a_z    <= z0;
            vertex_b_x    <= xy[6];
            vertex_b_y    <= xy[7];
            vertex_b_z    <= z1;
            vertex_c_x    <= xy[4];
            vertex_c_y    <= xy[5];
            vertex_c_z    <= z0;
            triangle_kind <= 1'b1;
            run_last      <= 1'b1;
            sphere_done   <= done_f;
            lo_pend       <= 1'b0;
            state         <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // checks
  `SMTG_NEVER(seq_in_range, state == CALC && seq > LAST_STEP)
  `SMTG_ASSERT(done_marks_last, tri_valid && sphere_done |-> run_last)
  `SMTG_ASSERT(no_pop_busy, pop |-> state == IDLE && head.valid)
  `SMTG_ASSERT(lower_sets_last, tri_valid && triangle_kind |-> run_last)

endmodule
